FILE: hw/rtl/md5_pkg.sv
// md5 package: request and digest payload types, sequencer codes, round tables
// no dependencies; used by md5_message_digest

package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } msg_t;

  typedef struct packed {
    logic [63:0] digest_half;
    logic        half_is_last;
  } dig_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOAD  = 4'b0010,
    S_ROUND = 4'b0100,
    S_FOLD  = 4'b1000
  } state_t;

  // kind of block being compressed
  typedef enum logic [1:0] {
    PAD_NONE   = 2'd0,  // full block of message bytes
    PAD_ONE    = 2'd1,  // tail bytes, 0x80 marker and length
    PAD_FIRST  = 2'd2,  // tail bytes and marker, no room for length
    PAD_SECOND = 2'd3   // zeros and length
  } pad_mode_t;

  localparam logic [31:0] CHAIN_INIT [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [5:0] LEN_ROOM   = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // message word used by a round, all arithmetic mod 16
  function automatic logic [3:0] round_pick(input logic [5:0] r);
    logic [3:0] n;
    logic [3:0] p;
    n = r[3:0];
    case (r[5:4])
      2'd0:    p = n;
      2'd1:    p = {n[1:0], 2'b00} + n + 4'd1;
      2'd2:    p = {n[2:0], 1'b0} + n + 4'd5;
      2'd3:    p = {n[0], 3'b000} - n;
      default: p = n;
    endcase
    return p;
  endfunction

endpackage

FILE: hw/rtl/md5_message_digest.sv
// md5 message digest: byte gathering, padding and iterative 64-round compression
// depends on md5_pkg (payload types, round tables, sequencer codes)

// usage
//   msg channel (msg_valid / msg_ready / msg) takes one request per message byte;
//   a request with end_of_message closes the message, with or without a byte.
//   dig channel (dig_valid / dig_ready / dig) returns two requests per message:
//   digest bytes 0..7 (half_is_last = 0), then bytes 8..15 (half_is_last = 1).
// timing
//   a byte that does not fill a block is taken without leaving the idle state.
//   each block passes through one shared round unit: a load step, 64 rounds at
//   one round per cycle, then a fold into the chain.
//   the 64th byte starts a block; an end request adds one or two padding
//   blocks (two when 56 or more bytes sit in the last block), so the first
//   digest half appears after one or two block compressions (also two when
//   the end request carries the 64th byte). msg_ready is low during compression.
// stalls and reset
//   the digest sits in its own holding register, so the next message streams in
//   while the receiver stalls; only the fold of the next digest waits for it.
//   rst clears the sequencer, counts and output valid and loads the initial chain.

module md5_message_digest
  import md5_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic msg_valid,
  output logic msg_ready,
  input  msg_t msg,
  output logic dig_valid,
  input  logic dig_ready,
  output dig_t dig
);

  state_t      state;
  pad_mode_t   mode;
  logic        pend_end;     // end seen on the byte that closed a full block
  logic [5:0]  rnd;          // round counter
  logic [5:0]  fill;         // bytes held in the current block
  logic [60:0] msg_bytes;    // message length in bytes, wraps
  logic [31:0] chain [4];
  logic [31:0] rr [4];       // working registers a, b, c, d
  logic [31:0] km;           // round constant plus message word, one round ahead
  logic [31:0] store [16];   // block buffer, little-endian bytes
  logic [127:0] hold;        // digest waiting for the receiver
  logic        hold_valid;
  logic        out_half;

  logic        msg_fire;
  logic [5:0]  fill_inc;
  logic [5:0]  fill_end;
  logic [5:0]  sel_r;
  logic [3:0]  pick;
  logic [6:0]  lim;
  logic        mark_en;
  logic        len_en;
  logic [63:0] bit_len;
  logic [31:0] eff_word;
  logic [31:0] km_next;
  logic [31:0] mix;
  logic [31:0] t_sum;
  logic [63:0] t_dbl;
  logic [31:0] b_new;
  logic [31:0] sums [4];
  logic        final_blk;

  assign msg_ready = (state == S_IDLE);
  assign msg_fire  = msg_valid && msg_ready;
  assign fill_inc  = fill + 6'd1;
  assign fill_end  = msg.byte_present ? fill_inc : fill;
  assign final_blk = (mode == PAD_ONE) || (mode == PAD_SECOND);

  assign dig_valid        = out_half || hold_valid;
  assign dig.digest_half  = out_half ? hold[127:64] : hold[63:0];
  assign dig.half_is_last = out_half;

  // padding window of the block in flight
  always_comb begin
    lim     = 7'd64;
    mark_en = 1'b0;
    len_en  = 1'b0;
    case (mode)
      PAD_NONE: begin
        lim = 7'd64;
      end
      PAD_ONE: begin
        lim     = {1'b0, fill};
        mark_en = 1'b1;
        len_en  = 1'b1;
      end
      PAD_FIRST: begin
        lim     = {1'b0, fill};
        mark_en = 1'b1;
      end
      PAD_SECOND: begin
        lim    = 7'd0;
        len_en = 1'b1;
      end
      default: begin
        lim = 7'd64;
      end
    endcase
  end

  assign bit_len = {msg_bytes, 3'b000};

  // message word for the round after this one, with padding applied on read
  assign sel_r = (state == S_ROUND) ? rnd + 6'd1 : rnd;
  assign pick  = round_pick(sel_r);

  always_comb begin
    logic [6:0] pos;
    eff_word = '0;
    for (int k = 0; k < 4; k++) begin
      pos = {1'b0, pick, 2'(k)};
      if (pos < lim) begin
        eff_word[8*k +: 8] = store[pick][8*k +: 8];
      end else if (mark_en && (pos == lim)) begin
        eff_word[8*k +: 8] = PAD_MARK;
      end
    end
    if (len_en && (pick == 4'd14)) begin
      eff_word = bit_len[31:0];
    end else if (len_en && (pick == 4'd15)) begin
      eff_word = bit_len[63:32];
    end
  end

  assign km_next = round_k(sel_r) + eff_word;

  // shared round unit
  always_comb begin
    case (rnd[5:4])
      2'd0:    mix = (rr[1] & rr[2]) | (~rr[1] & rr[3]);
      2'd1:    mix = (rr[3] & rr[1]) | (~rr[3] & rr[2]);
      2'd2:    mix = rr[1] ^ rr[2] ^ rr[3];
      2'd3:    mix = rr[2] ^ (rr[1] | ~rr[3]);
      default: mix = rr[1] ^ rr[2] ^ rr[3];
    endcase
  end

  assign t_sum = rr[0] + mix + km;
  assign t_dbl = {t_sum, t_sum} << round_s(rnd);
  assign b_new = rr[1] + t_dbl[63:32];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sums[i] = chain[i] + rr[i];
    end
  end

  // block buffer write, one byte per request
  always_ff @(posedge clk) begin
    if (msg_fire && msg.byte_present) begin
      store[fill[5:2]][8*fill[1:0] +: 8] <= msg.data_byte;
    end
  end

  // round datapath
  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      for (int i = 0; i < 4; i++) begin
        rr[i] <= chain[i];
      end
      km <= km_next;
    end else if (state == S_ROUND) begin
      rr[0] <= rr[3];
      rr[1] <= b_new;
      rr[2] <= rr[1];
      rr[3] <= rr[2];
      km    <= km_next;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FOLD) && final_blk && !dig_valid) begin
      hold <= {sums[3], sums[2], sums[1], sums[0]};
    end
  end

  // sequencer and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mode       <= PAD_NONE;
      pend_end   <= 1'b0;
      rnd        <= '0;
      fill       <= '0;
      msg_bytes  <= '0;
      hold_valid <= 1'b0;
      out_half   <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        chain[i] <= CHAIN_INIT[i];
      end
    end else begin
      // first half, then second half, then free
      if (dig_valid && dig_ready) begin
        if (!out_half) begin
          out_half   <= 1'b1;
          hold_valid <= 1'b0;
        end else begin
          out_half <= 1'b0;
        end
      end

      case (state)
        S_IDLE: begin
          rnd <= '0;
          if (msg_fire) begin
            if (msg.byte_present) begin
              fill      <= fill_inc;
              msg_bytes <= msg_bytes + 61'd1;
            end
            if (msg.byte_present && (fill == LAST_ROUND)) begin
              // block full: compress it, padding follows if the message ends
              state    <= S_LOAD;
              mode     <= PAD_NONE;
              pend_end <= msg.end_of_message;
            end else if (msg.end_of_message) begin
              state <= S_LOAD;
              mode  <= (fill_end >= LEN_ROOM) ? PAD_FIRST : PAD_ONE;
            end
          end
        end
        S_LOAD: begin
          rnd   <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == LAST_ROUND) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          if (final_blk) begin
            // digest waits until the previous one has gone out
            if (!dig_valid) begin
              hold_valid <= 1'b1;
              for (int i = 0; i < 4; i++) begin
                chain[i] <= CHAIN_INIT[i];
              end
              fill      <= '0;
              msg_bytes <= '0;
              mode      <= PAD_NONE;
              state     <= S_IDLE;
            end
          end else begin
            for (int i = 0; i < 4; i++) begin
              chain[i] <= sums[i];
            end
            if (mode == PAD_FIRST) begin
              mode  <= PAD_SECOND;
              state <= S_LOAD;
            end else if (pend_end) begin
              mode     <= PAD_ONE;
              pend_end <= 1'b0;
              state    <= S_LOAD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/tb_top.sv
// testbench for md5_message_digest: random and directed messages, byte by byte
// predicts each digest with its own md5 model; depends on md5_pkg for payload types

module tb_top;
  import md5_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 5;
  // cycles with no request moving on either channel before the run is abandoned;
  // covers the long receiver hold, the worst two-block compression and random gaps
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 1500;
  localparam int DRAIN_CYCLES = 300;
  localparam int NOISE_PCT = 5;

  // md5 sine-derived additive constants, one per round
  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // rotate amounts, indexed by {round group, round mod 4}
  localparam int SHIFT_AMT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  localparam logic [31:0] IV [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [7:0] MARKER_BYTE = 8'h80;
  localparam int LENGTH_SLOT = 56;

  logic clk;
  logic rst;
  logic msg_valid;
  logic msg_ready;
  msg_t msg;
  logic dig_valid;
  logic dig_ready;
  dig_t dig;

  md5_message_digest i_dut (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg       (msg),
    .dig_valid (dig_valid),
    .dig_ready (dig_ready),
    .dig       (dig)
  );

  // predictor state: chaining words, current block, fill level, message length
  logic [31:0] chain_w [4];
  logic [31:0] block_w [16];
  logic [5:0]  fill_cnt;
  logic [60:0] msg_bytes;

  // digest halves still owed by the block, oldest first
  dig_t pending_digests [$];

  int errors = 0;
  int items_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // md5 predictor
  // ---------------------------------------------------------------------------

  // one 64-round compression of block_w into chain_w
  function automatic void md5_compress();
    logic [31:0] a, b, c, d, mix, sum, spun;
    int pick, sh;
    a = chain_w[0];
    b = chain_w[1];
    c = chain_w[2];
    d = chain_w[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          mix = (b & c) | (~b & d);
          pick = r;
        end
        1: begin
          mix = (d & b) | (~d & c);
          pick = (5 * r + 1) % 16;
        end
        2: begin
          mix = b ^ c ^ d;
          pick = (3 * r + 5) % 16;
        end
        default: begin
          mix = c ^ (b | ~d);
          pick = (7 * r) % 16;
        end
      endcase
      sh = SHIFT_AMT[(r / 16) * 4 + (r % 4)];
      sum = a + mix + SINE_K[r] + block_w[pick];
      spun = (sum << sh) | (sum >> (32 - sh));
      a = d;
      d = c;
      c = b;
      b = b + spun;
    end
    chain_w[0] += a;
    chain_w[1] += b;
    chain_w[2] += c;
    chain_w[3] += d;
  endfunction

  // little-endian byte placement within the block
  function automatic void place_byte(input logic [5:0] pos, input logic [7:0] val);
    block_w[pos[5:2]][pos[1:0] * 8 +: 8] = val;
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 4; i++) chain_w[i] = IV[i];
    fill_cnt = '0;
    msg_bytes = '0;
  endfunction

  // absorb one accepted request; an end request queues both digest halves
  function automatic void absorb_request(input msg_t m);
    logic [63:0] bit_len;
    dig_t lo_half, hi_half;
    if (m.byte_present) begin
      place_byte(fill_cnt, m.data_byte);
      fill_cnt++;
      msg_bytes++;
      if (fill_cnt == 0) md5_compress();
    end
    if (!m.end_of_message) return;
    // padding: marker, zeros, then the bit length in the last two words
    place_byte(fill_cnt, MARKER_BYTE);
    for (int p = fill_cnt + 1; p < 64; p++) place_byte(p[5:0], 8'h00);
    if (fill_cnt >= LENGTH_SLOT) begin
      md5_compress();
      for (int i = 0; i < 16; i++) block_w[i] = '0;
    end
    bit_len = {msg_bytes, 3'b000};
    block_w[14] = bit_len[31:0];
    block_w[15] = bit_len[63:32];
    md5_compress();
    lo_half.digest_half = {chain_w[1], chain_w[0]};
    lo_half.half_is_last = 1'b0;
    hi_half.digest_half = {chain_w[3], chain_w[2]};
    hi_half.half_is_last = 1'b1;
    pending_digests.push_back(lo_half);
    pending_digests.push_back(hi_half);
    restart_message();
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: called and returns just after a falling edge
  // ---------------------------------------------------------------------------

  task automatic send_request(input msg_t m);
    while ($urandom_range(99) < idle_pct) begin
      msg_valid <= 1'b0;
      msg <= msg_t'($urandom);
      @(negedge clk);
    end
    msg_valid <= 1'b1;
    msg <= m;
    do @(posedge clk); while (!msg_ready);
    absorb_request(m);
    if (m.byte_present || m.end_of_message) items_sent++;
    @(negedge clk);
  endtask

  // drop valid once the stream pauses
  task automatic stop_requests();
    msg_valid <= 1'b0;
  endtask

  function automatic msg_t make_request(input logic [7:0] b, input bit has_byte,
                                        input bit is_end);
    msg_t m;
    m.data_byte = b;
    m.byte_present = has_byte;
    m.end_of_message = is_end;
    return m;
  endfunction

  // a whole message of random bytes with occasional ignored requests mixed in;
  // the end rides on the last byte or comes as its own empty request
  task automatic send_message(input int len, input bit end_on_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < NOISE_PCT)
        send_request(make_request(8'($urandom), 1'b0, 1'b0));
      send_request(make_request(8'($urandom), 1'b1, end_on_byte && (i == len - 1)));
    end
    if (!end_on_byte || len == 0)
      send_request(make_request(8'($urandom), 1'b0, 1'b1));
  endtask

  // lengths cluster on the padding and block boundaries
  function automatic int pick_length();
    int edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    case ($urandom_range(3))
      0: return $urandom_range(8);
      1: return edges[$urandom_range(9)];
      2: return $urandom_range(130);
      default: return $urandom_range(60, 9);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // digest receiver: random stalls, plus one long hold on request
  // ---------------------------------------------------------------------------

  initial begin
    dig_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        dig_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end
      dig_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // digest checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_digest
    dig_t want;
    if (!rst && dig_valid && dig_ready) begin
      if (pending_digests.size() == 0) begin
        $error("digest_half: unexpected request, actual %h", dig.digest_half);
        errors++;
      end else begin
        want = pending_digests.pop_front();
        if (dig.digest_half !== want.digest_half) begin
          $error("digest_half: expected %h, actual %h", want.digest_half, dig.digest_half);
          errors++;
        end
        if (dig.half_is_last !== want.half_is_last) begin
          $error("half_is_last: expected %b, actual %b", want.half_is_last,
                 dig.half_is_last);
          errors++;
        end
      end
    end
  end

  // watchdog: no request moving on either side for too long
  always @(posedge clk) begin
    if (rst || (msg_valid && msg_ready) || (dig_valid && dig_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // empty message, alone and after an ignored request
  task automatic test_empty_message();
    send_request(make_request(8'h00, 1'b0, 1'b1));
    send_request(make_request(8'hff, 1'b0, 1'b0));
    send_request(make_request(8'hff, 1'b0, 1'b1));
  endtask

  // single extreme bytes, with the end on the byte and on its own
  task automatic test_single_bytes();
    send_request(make_request(8'h00, 1'b1, 1'b1));
    send_request(make_request(8'hff, 1'b1, 1'b1));
    send_request(make_request(8'h80, 1'b1, 1'b0));
    send_request(make_request(8'h00, 1'b0, 1'b1));
  endtask

  // "abc", then a short message with ignored requests between its bytes
  task automatic test_short_text();
    send_request(make_request(8'h61, 1'b1, 1'b0));
    send_request(make_request(8'h62, 1'b1, 1'b0));
    send_request(make_request(8'h63, 1'b1, 1'b0));
    send_request(make_request(8'h00, 1'b0, 1'b1));
    send_request(make_request(8'h01, 1'b1, 1'b0));
    send_request(make_request(8'h55, 1'b0, 1'b0));
    send_request(make_request(8'hfe, 1'b1, 1'b0));
    send_request(make_request(8'haa, 1'b0, 1'b0));
    send_request(make_request(8'h7f, 1'b1, 1'b1));
  endtask

  task automatic test_random_messages(input int budget, input int snd_idle,
                                      input int rcv_stall);
    int target;
    idle_pct = snd_idle;
    stall_pct = rcv_stall;
    target = items_sent + budget;
    while (items_sent < target)
      send_message(pick_length(), 1'($urandom_range(1)));
    stop_requests();
  endtask

  // receiver holds off while several messages arrive, so the held digest
  // blocks the next fold and the input side backs up
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1;
    for (int i = 0; i < 4; i++)
      send_message($urandom_range(20, 1), 1'($urandom_range(1)));
    stop_requests();
  endtask

  initial begin
    rst = 1'b1;
    msg_valid = 1'b0;
    msg = '0;
    restart_message();
    for (int i = 0; i < 16; i++) block_w[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_message();
    test_single_bytes();
    test_short_text();
    test_random_messages(300, 0, 0);
    test_random_messages(250, 81, 0);
    test_random_messages(250, 0, 81);
    test_backpressure();
    test_random_messages(250, 24, 24);

    // let every owed digest arrive, then watch for strays
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
